FILE: design/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; every module of the block imports this package.
package mi3_pkg;

    localparam int N_DIM  = 3;
    localparam int N_ELEM = 9;

    // tuser bit positions on the result channel
    localparam int USER_SINGULAR  = 0;
    localparam int USER_SATURATED = 1;
    localparam int USER_W         = 2;

    // control that travels with the pipe from stage D through the divider
    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

endpackage

FILE: design/matrix3x3_lu_inverse_top.sv
// Throughput: one matrix per cycle while no result is held; set by the pipelined
//   divider, which resolves one quotient bit per stage for all nine lanes in parallel.
// Reset: synchronous, active low; clears the stage valid bits only.
// Stall: a held result freezes the whole pipe; nothing is dropped or repeated.
// Holds mi3_cofactor, mi3_det, mi3_div_step and mi3_output; uses mi3_pkg.
module matrix3x3_lu_inverse_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // in_r0c0, in_r0c1, ... in_r2c2, DATA_WIDTH bits each, zero padded to bytes
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]          i_s_tdata,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // out_r0c0, out_r0c1, ... out_r2c2, DATA_WIDTH bits each, zero padded to bytes
    output logic [((9*DATA_WIDTH+7)/8)*8-1:0]          o_m_tdata,
    // bit 0 singular, bit 1 saturated
    output logic [mi3_pkg::USER_W-1:0]                 o_m_tuser
);
    import mi3_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int TW = ((9*DATA_WIDTH+7)/8)*8;
    localparam int SW = 4*W + 2*F + 4;
    localparam int QW = W + 1;          // quotient bits, top bit marks overflow

    // advance the whole pipe unless a finished result is waiting
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // unpack the input matrix
    logic signed [W-1:0] in_elem [N_ELEM];
    for (genvar k = 0; k < N_ELEM; k++) begin : g_in
        assign in_elem[k] = i_s_tdata[k*W +: W];
    end

    // stage A: cofactors
    logic                cf_valid;
    logic signed [W-1:0] cf_row0 [N_DIM];
    logic signed [2*W:0] cf_cof  [N_ELEM];

    mi3_cofactor #(.W(W)) u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_elem  (in_elem),
        .o_valid (cf_valid),
        .o_row0  (cf_row0),
        .o_cof   (cf_cof)
    );

    // stages B..D: determinant, dividend per lane and the shared divisor
    t_ctl          st_ctl [QW+1];
    logic [SW-1:0] st_r   [QW+1][N_ELEM];
    logic [SW-1:0] st_y   [QW+1];
    logic [W:0]    st_q   [QW+1][N_ELEM];
    logic          st_neg [QW+1][N_ELEM];

    mi3_det #(.W(W), .F(F), .SW(SW)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cf_valid),
        .i_row0  (cf_row0),
        .i_cof   (cf_cof),
        .o_ctl   (st_ctl[0]),
        .o_x     (st_r[0]),
        .o_y     (st_y[0]),
        .o_neg   (st_neg[0])
    );

    for (genvar k = 0; k < N_ELEM; k++) begin : g_q0
        assign st_q[0][k] = '0;
    end

    // divider: quotient bit W first, down to bit 0
    for (genvar s = 0; s < QW; s++) begin : g_div
        mi3_div_step #(.W(W), .SW(SW), .BIT(W - s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (st_ctl[s]),
            .i_r     (st_r[s]),
            .i_y     (st_y[s]),
            .i_q     (st_q[s]),
            .i_neg   (st_neg[s]),
            .o_ctl   (st_ctl[s+1]),
            .o_r     (st_r[s+1]),
            .o_y     (st_y[s+1]),
            .o_q     (st_q[s+1]),
            .o_neg   (st_neg[s+1])
        );
    end

    // final stage: clamp, apply sign, pack the result transaction
    mi3_output #(.W(W), .TW(TW)) u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (st_ctl[QW]),
        .i_q     (st_q[QW]),
        .i_neg   (st_neg[QW]),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser)
    );
endmodule

FILE: design/mi3_cofactor.sv
// First stage: the nine 2x2 cofactors of the input matrix, registered.
// Depends on mi3_pkg.
module mi3_cofactor #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_elem [mi3_pkg::N_ELEM],
    output logic                 o_valid,
    output logic signed [W-1:0]  o_row0 [mi3_pkg::N_DIM],
    output logic signed [2*W:0]  o_cof  [mi3_pkg::N_ELEM]
);
    import mi3_pkg::*;

    logic                r_valid;
    logic signed [W-1:0] r_row0 [N_DIM];
    logic signed [2*W:0] r_cof  [N_ELEM];
    logic signed [2*W:0] n_cof  [N_ELEM];

    for (genvar r = 0; r < N_DIM; r++) begin : g_row
        for (genvar c = 0; c < N_DIM; c++) begin : g_col
            localparam int R1 = (r + 1) % N_DIM;
            localparam int R2 = (r + 2) % N_DIM;
            localparam int C1 = (c + 1) % N_DIM;
            localparam int C2 = (c + 2) % N_DIM;
            logic signed [2*W-1:0] pa, pb;
            assign pa = i_elem[R1*N_DIM+C1] * i_elem[R2*N_DIM+C2];
            assign pb = i_elem[R1*N_DIM+C2] * i_elem[R2*N_DIM+C1];
            assign n_cof[r*N_DIM+c] = {pa[2*W-1], pa} - {pb[2*W-1], pb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cof <= n_cof;
            for (int c = 0; c < N_DIM; c++) begin
                r_row0[c] <= i_elem[c];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_row0  = r_row0;
    assign o_cof   = r_cof;
endmodule

FILE: design/mi3_det.sv
// Determinant over three stages (split products, sum, magnitude), then the
// dividend of every output lane and their shared divisor. Depends on mi3_pkg.
module mi3_det #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SW = 4*W + 2*F + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_row0 [mi3_pkg::N_DIM],
    input  logic signed [2*W:0]  i_cof  [mi3_pkg::N_ELEM],
    output mi3_pkg::t_ctl        o_ctl,
    output logic [SW-1:0]        o_x    [mi3_pkg::N_ELEM],
    output logic [SW-1:0]        o_y,
    output logic                 o_neg  [mi3_pkg::N_ELEM]
);
    import mi3_pkg::*;

    localparam int CW = 2*W + 1;
    localparam int DW = 3*W + 3;

    // stage B: partial products of row 0 by its cofactors
    logic                r_vb;
    logic signed [CW-1:0] r_plo [N_DIM];
    logic signed [CW-1:0] r_phi [N_DIM];
    logic signed [CW-1:0] r_cofb [N_ELEM];
    logic signed [CW-1:0] n_plo [N_DIM];
    logic signed [CW-1:0] n_phi [N_DIM];

    for (genvar c = 0; c < N_DIM; c++) begin : g_pp
        logic signed [CW-1:0] ea, elo, ehi;
        assign ea  = {{(W+1){i_row0[c][W-1]}}, i_row0[c]};
        assign elo = {{(W+1){1'b0}}, i_cof[c][W-1:0]};
        assign ehi = {{W{i_cof[c][CW-1]}}, i_cof[c][CW-1:W]};
        assign n_plo[c] = ea * elo;
        assign n_phi[c] = ea * ehi;
    end

    // stage C: determinant sum
    logic                 r_vc;
    logic signed [DW-1:0] r_det;
    logic signed [CW-1:0] r_cofc [N_ELEM];
    logic signed [DW-1:0] n_det;

    always_comb begin
        n_det = '0;
        for (int c = 0; c < N_DIM; c++) begin
            n_det = n_det + ({{(DW-CW){r_plo[c][CW-1]}}, r_plo[c]})
                          + ({{(DW-CW){r_phi[c][CW-1]}}, r_phi[c]} <<< W);
        end
    end

    // stage D: magnitudes, transposed lanes, rounding offset in the dividend
    t_ctl            r_ctl;
    logic [SW-1:0]   r_x   [N_ELEM];
    logic [SW-1:0]   r_y;
    logic            r_neg [N_ELEM];
    logic [SW-1:0]   n_x   [N_ELEM];
    logic            n_neg [N_ELEM];
    logic [DW-1:0]   dmag;

    assign dmag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);

    for (genvar r = 0; r < N_DIM; r++) begin : g_lr
        for (genvar c = 0; c < N_DIM; c++) begin : g_lc
            logic signed [CW-1:0] cf;
            logic [CW-1:0]        cmag;
            assign cf   = r_cofc[c*N_DIM+r];
            assign cmag = cf[CW-1] ? CW'(-cf) : CW'(cf);
            assign n_x[r*N_DIM+c]   = (SW'(cmag) << (2*F + 1)) + SW'(dmag);
            assign n_neg[r*N_DIM+c] = cf[CW-1] ^ r_det[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_vb           <= i_valid;
            r_vc           <= r_vb;
            r_ctl.valid    <= r_vc;
            r_ctl.singular <= (r_det == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo          <= n_plo;
            r_phi          <= n_phi;
            r_cofb         <= i_cof;
            r_det          <= n_det;
            r_cofc         <= r_cofb;
            r_x            <= n_x;
            r_neg          <= n_neg;
            r_y            <= SW'(dmag) << 1;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_neg = r_neg;
endmodule

FILE: design/mi3_div_step.sv
// One restoring-division step for all nine lanes: compare against the
// divisor shifted by BIT, subtract, shift the quotient bit in. Uses mi3_pkg.
module mi3_div_step #(
    parameter int W   = 32,
    parameter int SW  = 164,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  mi3_pkg::t_ctl        i_ctl,
    input  logic [SW-1:0]        i_r   [mi3_pkg::N_ELEM],
    input  logic [SW-1:0]        i_y,
    input  logic [W:0]           i_q   [mi3_pkg::N_ELEM],
    input  logic                 i_neg [mi3_pkg::N_ELEM],
    output mi3_pkg::t_ctl        o_ctl,
    output logic [SW-1:0]        o_r   [mi3_pkg::N_ELEM],
    output logic [SW-1:0]        o_y,
    output logic [W:0]           o_q   [mi3_pkg::N_ELEM],
    output logic                 o_neg [mi3_pkg::N_ELEM]
);
    import mi3_pkg::*;

    t_ctl          r_ctl;
    logic [SW-1:0] r_r   [N_ELEM];
    logic [SW-1:0] r_y;
    logic [W:0]    r_q   [N_ELEM];
    logic          r_neg [N_ELEM];
    logic [SW-1:0] n_r   [N_ELEM];
    logic [W:0]    n_q   [N_ELEM];
    logic [SW-1:0] ys;

    assign ys = i_y << BIT;

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            if (i_r[k] >= ys) begin
                n_r[k] = i_r[k] - ys;
                n_q[k] = {i_q[k][W-1:0], 1'b1};
            end else begin
                n_r[k] = i_r[k];
                n_q[k] = {i_q[k][W-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid    <= i_ctl.valid;
            r_ctl.singular <= i_ctl.singular;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r            <= n_r;
            r_y            <= i_y;
            r_q            <= n_q;
            r_neg          <= i_neg;
        end
    end

    assign o_ctl = r_ctl;
    assign o_r   = r_r;
    assign o_y   = r_y;
    assign o_q   = r_q;
    assign o_neg = r_neg;
endmodule

FILE: design/mi3_output.sv
// Result register: saturation, sign, singular override and packing.
// Depends on mi3_pkg.
module mi3_output #(
    parameter int W  = 32,
    parameter int TW = 288
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  mi3_pkg::t_ctl              i_ctl,
    input  logic [W:0]                 i_q   [mi3_pkg::N_ELEM],
    input  logic                       i_neg [mi3_pkg::N_ELEM],
    output logic                       o_valid,
    output logic [TW-1:0]              o_data,
    output logic [mi3_pkg::USER_W-1:0] o_user
);
    import mi3_pkg::*;

    logic                r_valid;
    logic [TW-1:0]       r_data;
    logic [USER_W-1:0]   r_user;
    logic [N_ELEM*W-1:0] n_vec;
    logic [USER_W-1:0]   n_user;
    logic [N_ELEM-1:0]   lane_sat;

    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        logic [W-1:0] qm, lim, mag;
        assign qm  = i_q[k][W-1:0];
        assign lim = i_neg[k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        assign lane_sat[k] = i_q[k][W] || (qm > lim);
        assign mag = lane_sat[k] ? lim : qm;
        assign n_vec[k*W +: W] = i_ctl.singular ? '0 : (i_neg[k] ? -mag : mag);
    end

    always_comb begin
        n_user                 = '0;
        n_user[USER_SINGULAR]  = i_ctl.singular;
        n_user[USER_SATURATED] = !i_ctl.singular && (|lane_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= TW'(n_vec);
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
endmodule
